// ===== rtl/rro_pkg.sv =====
// Package for the rotation re-orthonormalize core: widths, stage counts and vector types.
// No dependencies; every other file but rro_delay imports it.
package rro_pkg;

  localparam int IN_W        = 24;
  localparam int OUT_W       = 22;
  localparam int VEC_W       = 64;
  localparam int UNIT_W      = 32;
  localparam int INNER_FRAC  = 30;
  localparam int NORM_W      = 31;
  localparam int NORM_STAGES = 3;
  localparam int ROOT_W      = 32;
  localparam int SQ_STEPS    = ROOT_W;
  localparam int SQ_REM_W    = ROOT_W + 4;
  localparam int QUO_W       = NORM_W;
  localparam int NUM_W       = NORM_W + INNER_FRAC + 1;
  localparam int DIV_STEPS   = QUO_W;
  localparam int UNIT_LAT    = 1 + NORM_STAGES + 2 + SQ_STEPS + 1 + DIV_STEPS + 1;
  localparam int CROSS_LAT   = 2;
  localparam int SUM_LAT     = 1;
  localparam int OUT_LAT     = 3;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } wvec_t;

  typedef struct packed {
    logic signed [UNIT_W-1:0] x;
    logic signed [UNIT_W-1:0] y;
    logic signed [UNIT_W-1:0] z;
  } uvec_t;

endpackage

// ===== rtl/rro_in_if.sv =====
// Input channel: valid/ready handshake carrying one 3x3 matrix word.
// Depends on rro_pkg.
interface rro_in_if import rro_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [IN_W-1:0]  in_r0c0;
  logic signed [IN_W-1:0]  in_r0c1;
  logic signed [IN_W-1:0]  in_r0c2;
  logic signed [IN_W-1:0]  in_r1c0;
  logic signed [IN_W-1:0]  in_r1c1;
  logic signed [IN_W-1:0]  in_r1c2;
  logic signed [IN_W-1:0]  in_r2c0;
  logic signed [IN_W-1:0]  in_r2c1;
  logic signed [IN_W-1:0]  in_r2c2;

  modport source (output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                  in_r2c0, in_r2c1, in_r2c2, input ready);
  modport sink   (input valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                  in_r2c0, in_r2c1, in_r2c2, output ready);
endinterface

// ===== rtl/rro_out_if.sv =====
// Output channel: valid/ready handshake carrying one orthonormal matrix word.
// Depends on rro_pkg.
interface rro_out_if import rro_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [OUT_W-1:0]  out_r0c0;
  logic signed [OUT_W-1:0]  out_r0c1;
  logic signed [OUT_W-1:0]  out_r0c2;
  logic signed [OUT_W-1:0]  out_r1c0;
  logic signed [OUT_W-1:0]  out_r1c1;
  logic signed [OUT_W-1:0]  out_r1c2;
  logic signed [OUT_W-1:0]  out_r2c0;
  logic signed [OUT_W-1:0]  out_r2c1;
  logic signed [OUT_W-1:0]  out_r2c2;
  logic                     degenerate;

  modport source (output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
                  out_r2c0, out_r2c1, out_r2c2, degenerate, input ready);
  modport sink   (input valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
                  out_r2c0, out_r2c1, out_r2c2, degenerate, output ready);
endinterface

// ===== rtl/rro_delay.sv =====
// Enabled shift line that keeps side data aligned with the pipeline.
// Depends on nothing.
module rro_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe [D];

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= d;
      for (int i = 1; i < D; i++) pipe[i] <= pipe[i-1];
    end
  end

  assign q = pipe[D-1];

endmodule

// ===== rtl/rro_cross.sv =====
// Two-stage cross product of Q.30 vectors into exact Q.60.
// Depends on rro_pkg.
module rro_cross import rro_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  uvec_t a,
  input  uvec_t b,
  output wvec_t c
);

  logic signed [VEC_W-1:0] p [6];

  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= a.y * b.z;
      p[1] <= a.z * b.y;
      p[2] <= a.z * b.x;
      p[3] <= a.x * b.z;
      p[4] <= a.x * b.y;
      p[5] <= a.y * b.x;
      c.x  <= p[0] - p[1];
      c.y  <= p[2] - p[3];
      c.z  <= p[4] - p[5];
    end
  end

endmodule

// ===== rtl/rro_unit.sv =====
// Pipelined vector normalizer: block shift, square sum, bit-serial square root and
// one quotient bit per stage division to a Q.30 unit vector. Depends on rro_pkg.
module rro_unit import rro_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  wvec_t v,
  output uvec_t u,
  output logic  zero
);

  typedef struct packed {
    logic [2:0][NORM_W-1:0] m;
    logic [2:0]             neg;
    logic                   zero;
  } carry_t;

  logic [2:0][VEC_W-1:0]    mag_in;
  logic [2:0]               neg_in;
  logic [2:0][VEC_W-1:0]    nrm      [0:NORM_STAGES];
  logic [2:0]               nrm_neg  [0:NORM_STAGES];
  logic                     nrm_zero [0:NORM_STAGES];
  logic [2:0][2*NORM_W-1:0] sq;
  carry_t                   sq_c;
  logic [SQ_REM_W-1:0]      rt_rem   [0:SQ_STEPS];
  logic [ROOT_W-1:0]        rt_root  [0:SQ_STEPS];
  logic [VEC_W-1:0]         rt_src   [0:SQ_STEPS];
  carry_t                   rt_c     [0:SQ_STEPS];
  logic [2:0][NUM_W-1:0]    num;
  logic [2:0][ROOT_W-1:0]   dv_rem   [0:DIV_STEPS];
  logic [2:0][QUO_W-1:0]    dv_low   [0:DIV_STEPS];
  logic [2:0][QUO_W-1:0]    dv_q     [0:DIV_STEPS];
  logic [ROOT_W-1:0]        dv_r     [0:DIV_STEPS];
  carry_t                   dv_c     [0:DIV_STEPS];
  logic signed [UNIT_W-1:0] qs       [3];

  always_comb begin
    neg_in    = {v.z[VEC_W-1], v.y[VEC_W-1], v.x[VEC_W-1]};
    mag_in[0] = neg_in[0] ? VEC_W'(-v.x) : VEC_W'(v.x);
    mag_in[1] = neg_in[1] ? VEC_W'(-v.y) : VEC_W'(v.y);
    mag_in[2] = neg_in[2] ? VEC_W'(-v.z) : VEC_W'(v.z);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nrm[0]      <= mag_in;
      nrm_neg[0]  <= neg_in;
      nrm_zero[0] <= ((mag_in[0] | mag_in[1] | mag_in[2]) == '0);
    end
  end

  for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
    localparam int SA = (VEC_W / 2) >> (2 * k);
    localparam int SB = SA / 2;
    logic [2:0][VEC_W-1:0] a, b;
    logic [VEC_W-1:0]      oa, ob;

    always_comb begin
      oa = nrm[k][0] | nrm[k][1] | nrm[k][2];
      a  = nrm[k];
      if (oa[VEC_W-1 -: SA] == '0) begin
        for (int i = 0; i < 3; i++) a[i] = nrm[k][i] << SA;
      end
      ob = a[0] | a[1] | a[2];
      b  = a;
      if (ob[VEC_W-1 -: SB] == '0) begin
        for (int i = 0; i < 3; i++) b[i] = a[i] << SB;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nrm[k+1]      <= b;
        nrm_neg[k+1]  <= nrm_neg[k];
        nrm_zero[k+1] <= nrm_zero[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i]     <= (2*NORM_W)'(nrm[NORM_STAGES][i][VEC_W-1 -: NORM_W])
                   * (2*NORM_W)'(nrm[NORM_STAGES][i][VEC_W-1 -: NORM_W]);
        sq_c.m[i] <= nrm[NORM_STAGES][i][VEC_W-1 -: NORM_W];
      end
      sq_c.neg  <= nrm_neg[NORM_STAGES];
      sq_c.zero <= nrm_zero[NORM_STAGES];
      rt_src[0]  <= VEC_W'(sq[0]) + VEC_W'(sq[1]) + VEC_W'(sq[2]);
      rt_rem[0]  <= '0;
      rt_root[0] <= '0;
      rt_c[0]    <= sq_c;
    end
  end

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    logic [SQ_REM_W-1:0] sh, trial;
    logic                ge;

    always_comb begin
      sh    = {rt_rem[j][SQ_REM_W-3:0], rt_src[j][VEC_W-1 -: 2]};
      trial = SQ_REM_W'({rt_root[j], 2'b01});
      ge    = (sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt_rem[j+1]  <= ge ? sh - trial : sh;
        rt_root[j+1] <= {rt_root[j][ROOT_W-2:0], ge};
        rt_src[j+1]  <= rt_src[j] << 2;
        rt_c[j+1]    <= rt_c[j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = NUM_W'({rt_c[SQ_STEPS].m[i], {INNER_FRAC{1'b0}}})
             + NUM_W'(rt_root[SQ_STEPS] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= ROOT_W'(num[i][NUM_W-1 -: (NUM_W-QUO_W)]);
        dv_low[0][i] <= num[i][QUO_W-1:0];
        dv_q[0][i]   <= '0;
      end
      dv_r[0] <= rt_root[SQ_STEPS];
      dv_c[0] <= rt_c[SQ_STEPS];
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [2:0][ROOT_W:0] sh;
    logic [2:0]           ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        sh[i] = {dv_rem[j][i], dv_low[j][i][QUO_W-1]};
        ge[i] = (sh[i] >= {1'b0, dv_r[j]});
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem[j+1][i] <= ge[i] ? ROOT_W'(sh[i] - {1'b0, dv_r[j]}) : sh[i][ROOT_W-1:0];
          dv_low[j+1][i] <= dv_low[j][i] << 1;
          dv_q[j+1][i]   <= {dv_q[j][i][QUO_W-2:0], ge[i]};
        end
        dv_r[j+1] <= dv_r[j];
        dv_c[j+1] <= dv_c[j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) qs[i] = signed'(UNIT_W'(dv_q[DIV_STEPS][i]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u.x  <= dv_c[DIV_STEPS].neg[0] ? -qs[0] : qs[0];
      u.y  <= dv_c[DIV_STEPS].neg[1] ? -qs[1] : qs[1];
      u.z  <= dv_c[DIV_STEPS].neg[2] ? -qs[2] : qs[2];
      zero <= dv_c[DIV_STEPS].zero;
    end
  end

endmodule

// ===== rtl/rotation_reorthonormalize_core.sv =====
// Rotation re-orthonormalize core: nine Q3.20 entries in, nine orthonormal entries out.
// Depends on rro_pkg, rro_in_if, rro_out_if, rro_unit, rro_cross, rro_delay.
//
// Takes one matrix word per clock while the pipeline is not held and returns one word
// per matrix, in order, through five normalizer levels in series, each with a 32-step
// square root and a 31-step divider. The whole pipeline advances together; it holds
// when a finished word is waiting and the sink is not ready. A zero-length vector
// anywhere raises degenerate and returns the identity.
module rotation_reorthonormalize_core import rro_pkg::*; #(
  parameter int FRAC_BITS = 20
) (
  input logic            clk,
  input logic            rst,
  rro_in_if.sink         in_ch,
  rro_out_if.source      out_ch
);

  localparam int LAT = 5 * UNIT_LAT + 4 * CROSS_LAT + SUM_LAT + OUT_LAT;
  localparam int UP  = (FRAC_BITS >= INNER_FRAC) ? FRAC_BITS - INNER_FRAC : 0;
  localparam int DN  = (FRAC_BITS < INNER_FRAC) ? INNER_FRAC - FRAC_BITS : 0;
  localparam logic [VEC_W-1:0] RND = (DN > 0) ? (64'd1 << (DN - 1)) : 64'd0;
  localparam logic signed [VEC_W-1:0] ONE = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [VEC_W-1:0] SAT = 64'sd1 <<< (OUT_W - 1);
  localparam logic signed [VEC_W-1:0] HI  = (ONE < SAT - 1) ? ONE : SAT - 1;
  localparam logic signed [VEC_W-1:0] LO  = (-ONE > -SAT) ? -ONE : -SAT;

  function automatic logic signed [VEC_W-1:0] rnd_inner(input logic signed [VEC_W-1:0] w);
    logic [VEC_W-1:0] mag;
    mag = w[VEC_W-1] ? VEC_W'(-w) : VEC_W'(w);
    mag = (mag + (64'd1 << (INNER_FRAC - 1))) >> INNER_FRAC;
    return w[VEC_W-1] ? -signed'(mag) : signed'(mag);
  endfunction

  function automatic logic signed [VEC_W-1:0] scale(input logic signed [VEC_W-1:0] x);
    logic [VEC_W-1:0] mag;
    mag = x[VEC_W-1] ? VEC_W'(-x) : VEC_W'(x);
    mag = (mag + RND) >> DN;
    if (DN == 0) return x <<< UP;
    return x[VEC_W-1] ? -signed'(mag) : signed'(mag);
  endfunction

  function automatic logic signed [OUT_W-1:0] sat(input logic signed [VEC_W-1:0] x);
    if (x > HI) return OUT_W'(HI);
    if (x < LO) return OUT_W'(LO);
    return OUT_W'(x);
  endfunction

  logic                    en;
  logic [LAT-1:0]          vld;
  wvec_t                   l1_in [3];
  uvec_t                   l1_u  [3];
  uvec_t                   l1_d1 [3];
  uvec_t                   l1_d2 [3];
  logic [2:0]              l1_z;
  wvec_t                   c1    [3];
  uvec_t                   l2_u  [3];
  uvec_t                   l2_d  [3];
  logic [2:0]              l2_z;
  wvec_t                   c2    [3];
  uvec_t                   l3_u  [3];
  logic [2:0]              l3_z;
  wvec_t                   l4_in [3];
  uvec_t                   l4_u  [3];
  logic [2:0]              l4_z;
  wvec_t                   c3;
  uvec_t                   l5_u;
  logic                    l5_z;
  uvec_t                   res0_d1, res0_d2, res2_d;
  wvec_t                   wide;
  logic                    bad1_d, bad2, bad2_d, bad3, bad3_d, bad4, bad4_d, bad5, bad_d;
  logic signed [VEC_W-1:0] rv [9];
  logic signed [VEC_W-1:0] sv [9];
  logic                    rbad, sbad;
  logic signed [OUT_W-1:0] oq [9];
  logic                    odeg;

  assign en          = !vld[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;
  assign out_ch.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_ch.valid};
    end
  end

  always_comb begin
    l1_in[0].x = VEC_W'(in_ch.in_r0c0);
    l1_in[0].y = VEC_W'(in_ch.in_r0c1);
    l1_in[0].z = VEC_W'(in_ch.in_r0c2);
    l1_in[1].x = VEC_W'(in_ch.in_r1c0);
    l1_in[1].y = VEC_W'(in_ch.in_r1c1);
    l1_in[1].z = VEC_W'(in_ch.in_r1c2);
    l1_in[2].x = VEC_W'(in_ch.in_r2c0);
    l1_in[2].y = VEC_W'(in_ch.in_r2c1);
    l1_in[2].z = VEC_W'(in_ch.in_r2c2);
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    rro_unit u_l1 (.clk(clk), .en(en), .v(l1_in[i]), .u(l1_u[i]), .zero(l1_z[i]));
    rro_cross u_c1 (.clk(clk), .en(en), .a(l1_u[i]), .b(l1_u[(i+1)%3]), .c(c1[i]));
    rro_unit u_l2 (.clk(clk), .en(en), .v(c1[i]), .u(l2_u[i]), .zero(l2_z[i]));
    rro_delay #(.W($bits(uvec_t)), .D(CROSS_LAT + UNIT_LAT)) u_d1 (
      .clk(clk), .en(en), .d(l1_u[i]), .q(l1_d1[i]));
    rro_cross u_c2 (.clk(clk), .en(en), .a(l2_u[i]), .b(l1_d1[i]), .c(c2[i]));
    rro_unit u_l3 (.clk(clk), .en(en), .v(c2[i]), .u(l3_u[i]), .zero(l3_z[i]));
    rro_delay #(.W($bits(uvec_t)), .D(CROSS_LAT + UNIT_LAT)) u_d2 (
      .clk(clk), .en(en), .d(l1_d1[i]), .q(l1_d2[i]));
    rro_delay #(.W($bits(uvec_t)), .D(CROSS_LAT + UNIT_LAT)) u_d3 (
      .clk(clk), .en(en), .d(l2_u[i]), .q(l2_d[i]));

    always_ff @(posedge clk) begin
      if (en) begin
        l4_in[i].x <= VEC_W'(l1_d2[i].x) + VEC_W'(l2_d[(i+1)%3].x) + VEC_W'(l3_u[(i+2)%3].x);
        l4_in[i].y <= VEC_W'(l1_d2[i].y) + VEC_W'(l2_d[(i+1)%3].y) + VEC_W'(l3_u[(i+2)%3].y);
        l4_in[i].z <= VEC_W'(l1_d2[i].z) + VEC_W'(l2_d[(i+1)%3].z) + VEC_W'(l3_u[(i+2)%3].z);
      end
    end

    rro_unit u_l4 (.clk(clk), .en(en), .v(l4_in[i]), .u(l4_u[i]), .zero(l4_z[i]));
  end

  rro_cross u_c3 (.clk(clk), .en(en), .a(l4_u[0]), .b(l4_u[1]), .c(c3));
  rro_unit  u_l5 (.clk(clk), .en(en), .v(c3), .u(l5_u), .zero(l5_z));
  rro_delay #(.W($bits(uvec_t)), .D(CROSS_LAT + UNIT_LAT)) u_r0a (
    .clk(clk), .en(en), .d(l4_u[0]), .q(res0_d1));
  rro_cross u_c4 (.clk(clk), .en(en), .a(l5_u), .b(res0_d1), .c(wide));
  rro_delay #(.W($bits(uvec_t)), .D(CROSS_LAT)) u_r0b (
    .clk(clk), .en(en), .d(res0_d1), .q(res0_d2));
  rro_delay #(.W($bits(uvec_t)), .D(CROSS_LAT)) u_r2 (
    .clk(clk), .en(en), .d(l5_u), .q(res2_d));

  rro_delay #(.W(1), .D(CROSS_LAT + UNIT_LAT)) u_b1 (
    .clk(clk), .en(en), .d(|l1_z), .q(bad1_d));
  assign bad2 = bad1_d | (|l2_z);
  rro_delay #(.W(1), .D(CROSS_LAT + UNIT_LAT)) u_b2 (
    .clk(clk), .en(en), .d(bad2), .q(bad2_d));
  assign bad3 = bad2_d | (|l3_z);
  rro_delay #(.W(1), .D(SUM_LAT + UNIT_LAT)) u_b3 (
    .clk(clk), .en(en), .d(bad3), .q(bad3_d));
  assign bad4 = bad3_d | (|l4_z);
  rro_delay #(.W(1), .D(CROSS_LAT + UNIT_LAT)) u_b4 (
    .clk(clk), .en(en), .d(bad4), .q(bad4_d));
  assign bad5 = bad4_d | l5_z;
  rro_delay #(.W(1), .D(CROSS_LAT)) u_b5 (
    .clk(clk), .en(en), .d(bad5), .q(bad_d));

  always_ff @(posedge clk) begin
    if (en) begin
      rv[0] <= VEC_W'(res0_d2.x);
      rv[1] <= VEC_W'(res0_d2.y);
      rv[2] <= VEC_W'(res0_d2.z);
      rv[3] <= rnd_inner(wide.x);
      rv[4] <= rnd_inner(wide.y);
      rv[5] <= rnd_inner(wide.z);
      rv[6] <= VEC_W'(res2_d.x);
      rv[7] <= VEC_W'(res2_d.y);
      rv[8] <= VEC_W'(res2_d.z);
      rbad  <= bad_d;
      for (int k = 0; k < 9; k++) sv[k] <= scale(rv[k]);
      sbad  <= rbad;
      for (int k = 0; k < 9; k++) begin
        if (sbad) oq[k] <= (k % 4 == 0) ? OUT_W'(HI) : '0;
        else      oq[k] <= sat(sv[k]);
      end
      odeg  <= sbad;
    end
  end

  assign out_ch.out_r0c0   = oq[0];
  assign out_ch.out_r0c1   = oq[1];
  assign out_ch.out_r0c2   = oq[2];
  assign out_ch.out_r1c0   = oq[3];
  assign out_ch.out_r1c1   = oq[4];
  assign out_ch.out_r1c2   = oq[5];
  assign out_ch.out_r2c0   = oq[6];
  assign out_ch.out_r2c1   = oq[7];
  assign out_ch.out_r2c2   = oq[8];
  assign out_ch.degenerate = odeg;

`ifndef ASSERT_OFF
  a_degen_identity: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.degenerate |->
      out_ch.out_r0c1 == '0 && out_ch.out_r0c2 == '0 && out_ch.out_r1c0 == '0 &&
      out_ch.out_r1c2 == '0 && out_ch.out_r2c0 == '0 && out_ch.out_r2c1 == '0 &&
      out_ch.out_r0c0 == out_ch.out_r1c1 && out_ch.out_r1c1 == out_ch.out_r2c2)
    else $error("degenerate word is not the identity");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> $stable(vld))
    else $error("pipeline moved while the output word was held");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while the pipeline was held");
`endif

endmodule
